@@ sv/mesh_fit_and_ground_align_macros.svh @@
// ---------------------------------------------------------------------------
// mesh_fit_and_ground_align_macros
// Assertion helpers shared by the mesh normalizer RTL.
// ---------------------------------------------------------------------------
`ifndef MESH_FIT_AND_GROUND_ALIGN_MACROS_SVH
`define MESH_FIT_AND_GROUND_ALIGN_MACROS_SVH

// same-cycle implication, checked out of reset
`define MFGA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfga assertion failed");

// next-cycle implication, checked out of reset
`define MFGA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfga assertion failed");

`endif

@@ sv/mfga_pkg.sv @@
// ---------------------------------------------------------------------------
// mfga_pkg
// Shared types and constants of the mesh fit and ground-align block.
// ---------------------------------------------------------------------------
package mfga_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_IN_W = 64;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;

  localparam logic [31:0] DEF_FIT = 32'(2) << FRAC_BITS;
  localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

  // action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_ACCUM  = 3'd1;
  localparam logic [2:0] ACT_XFORM  = 3'd2;
  localparam logic [2:0] ACT_RENORM = 3'd3;
  localparam logic [2:0] ACT_REPORT = 3'd4;

  // config register indexes
  localparam logic REG_FIT = 1'b0;
  localparam logic REG_EN  = 1'b1;

  // transform source
  localparam logic [1:0] SRC_PT = 2'd0;
  localparam logic [1:0] SRC_LO = 2'd1;
  localparam logic [1:0] SRC_HI = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_EXT, S_SCALE, S_SCALE_W, S_DISP,
    S_XF_C, S_XF_D, S_XF_M, S_XF_R,
    S_NR_ABS, S_NR_MAX, S_NR_SH, S_NR_MUL, S_NR_ACC,
    S_NR_SQRT, S_NR_SQW, S_NR_DIV, S_NR_DIVW, S_EMIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ sv/mesh_fit_and_ground_align.sv @@
// ---------------------------------------------------------------------------
// mesh_fit_and_ground_align
// Two-pass mesh normalizer: bounding box, fit/ground-align, normal renorm.
// ---------------------------------------------------------------------------
// Usage:
//  - in_* stream: tuser = action, tdata = {z, y, x} (x in the low 32 bits).
//    Action 0 clears the box, 1 folds a point into it, 2 transforms a
//    point, 3 renormalizes a normal, 4 reports the transformed box as two
//    beats (min, then max with tlast). Actions 5..7 are dropped.
//  - out_* stream: tdata = {z, y, x}, tuser = applied, tlast = last beat.
//  - cfg_*: write-only; index 0 = fit_extent, 1 = normalize_enable. Write
//    only while the block is idle.
// Timing: one beat at a time, in_tready is high only in the idle state.
//  Actions 0/1 are handled in the idle state. The box extent scan steps
//  through the three axes; a scale refresh after the box or fit changed
//  adds a division (64-step divider). A point transform then runs centre,
//  offset, multiply and round for each axis through the shared multiplier.
//  A normal runs a normalizing shift, the square-root unit and three
//  divisions, after a scale refresh when one is due. A report takes two
//  point transforms.
// Stall: the result sits in an output register; a new result waits in the
//  sequencer until that register drains.
// Reset: rst_n (sync, active low) empties the box, invalidates the scale and
//  restores fit 2.0 with normalizing enabled.
// ---------------------------------------------------------------------------
`include "mesh_fit_and_ground_align_macros.svh"

module mesh_fit_and_ground_align (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [0:0]  out_tuser,  // applied[0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [30:0] cfg_wdata
);

  localparam int FB = mfga_pkg::FRAC_BITS;
  localparam int RW = 64 - FB + 1;

  mfga_pkg::state_t state_r, state_nxt;

  // config
  logic [30:0]        fit_r;
  logic               en_r;

  // box and scale
  logic signed [31:0] low_r  [3];
  logic signed [31:0] high_r [3];
  logic               have_r;
  logic [31:0]        scale_r;
  logic               scale_ok_r;

  // per-item working state
  logic [2:0]         act_code_r;
  logic signed [31:0] p_r [3];
  logic [1:0]         k_r;
  logic [1:0]         src_r;
  logic               phase_r;
  logic               act_r;
  logic [31:0]        ext_r;
  logic signed [32:0] ctr_r;
  logic [32:0]        mag_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  logic [31:0]        a_r [3];
  logic [2:0]         sgn_r;
  logic [31:0]        m_r;
  logic [63:0]        sum_r;
  logic [31:0]        len_r;
  logic signed [31:0] res_r [3];
  logic               applied_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               oapp_r, olast_r;

  // control
  logic               in_go;
  logic               emit_go;
  mfga_pkg::div_req_t div_req;
  mfga_pkg::unit_sts_t div_sts, sq_sts;
  logic [63:0]        div_quo;
  logic               sq_start;
  logic [31:0]        sq_root;

  // ---- extent step ----
  logic signed [32:0] ext_diff;
  logic [31:0]        ext_step;
  logic               act_nxt;
  assign ext_diff = {high_r[k_r][31], high_r[k_r]} - {low_r[k_r][31], low_r[k_r]};
  assign ext_step = (high_r[k_r] > low_r[k_r] && ext_diff[31:0] > ext_r)
                    ? ext_diff[31:0] : ext_r;
  assign act_nxt  = en_r && have_r && (ext_step != '0);

  // ---- shared multiplier ----
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  assign mul_a = (state_r == mfga_pkg::S_XF_M) ? mag_r : {1'b0, a_r[k_r]};
  assign mul_b = (state_r == mfga_pkg::S_XF_M) ? scale_r : a_r[k_r];
  assign mul_p = mul_a * mul_b;

  // ---- transform datapath ----
  logic signed [32:0] ctr_sum;
  logic signed [31:0] src_val;
  logic signed [33:0] d_val;
  logic [RW-1:0]      rnd;
  logic signed [31:0] xf_out;
  // floor of the midpoint: arithmetic shift of the signed sum
  assign ctr_sum = $signed({low_r[k_r][31], low_r[k_r]} + {high_r[k_r][31], high_r[k_r]})
                   >>> 1;

  always_comb begin
    case (src_r)
      mfga_pkg::SRC_LO: src_val = low_r[k_r];
      mfga_pkg::SRC_HI: src_val = high_r[k_r];
      default:          src_val = p_r[k_r];
    endcase
  end

  assign d_val = {{2{src_val[31]}}, src_val} - {ctr_r[32], ctr_r};
  assign rnd   = {1'b0, prod_r[63:FB]} + RW'(prod_r[FB-1]);

  always_comb begin
    if (neg_r) begin
      xf_out = (rnd >= RW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(rnd[31:0]);
    end else begin
      xf_out = (rnd > RW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(rnd[31:0]);
    end
  end

  // ---- division requests ----
  logic [31:0] target;
  assign target = (fit_r == '0) ? mfga_pkg::DEF_FIT : {1'b0, fit_r};

  always_comb begin
    div_req = '0;
    if (state_r == mfga_pkg::S_SCALE) begin
      div_req.start = 1'b1;
      div_req.num   = ({32'b0, target} << FB) + {33'b0, ext_r[31:1]};
      div_req.den   = ext_r;
    end else if (state_r == mfga_pkg::S_NR_DIV) begin
      div_req.start = 1'b1;
      div_req.num   = ({32'b0, a_r[k_r]} << FB) + {33'b0, len_r[31:1]};
      div_req.den   = len_r;
    end
  end

  mfga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  mfga_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .sts      (sq_sts),
    .root     (sq_root)
  );

  // ---- outputs of the sequencer ----
  always_comb begin
    in_tready = state_r == mfga_pkg::S_IDLE;
    in_go     = in_tready && in_tvalid;
    emit_go   = (state_r == mfga_pkg::S_EMIT) && (!out_valid_r || out_tready);
    sq_start  = state_r == mfga_pkg::S_NR_SQRT;
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfga_pkg::S_IDLE: begin
        if (in_go && (in_tuser == mfga_pkg::ACT_XFORM || in_tuser == mfga_pkg::ACT_RENORM ||
                      in_tuser == mfga_pkg::ACT_REPORT))
          state_nxt = mfga_pkg::S_EXT;
      end
      mfga_pkg::S_EXT: begin
        if (k_r == 2'd2)
          state_nxt = (act_nxt && !scale_ok_r) ? mfga_pkg::S_SCALE : mfga_pkg::S_DISP;
      end
      mfga_pkg::S_SCALE:   state_nxt = mfga_pkg::S_SCALE_W;
      mfga_pkg::S_SCALE_W: if (div_sts.done) state_nxt = mfga_pkg::S_DISP;
      mfga_pkg::S_DISP: begin
        unique case (act_code_r)
          mfga_pkg::ACT_XFORM:  state_nxt = act_r ? mfga_pkg::S_XF_C : mfga_pkg::S_EMIT;
          mfga_pkg::ACT_RENORM: state_nxt = act_r ? mfga_pkg::S_NR_ABS : mfga_pkg::S_EMIT;
          default:              state_nxt = (have_r && act_r) ? mfga_pkg::S_XF_C
                                                              : mfga_pkg::S_EMIT;
        endcase
      end
      mfga_pkg::S_XF_C:    state_nxt = mfga_pkg::S_XF_D;
      mfga_pkg::S_XF_D:    state_nxt = mfga_pkg::S_XF_M;
      mfga_pkg::S_XF_M:    state_nxt = mfga_pkg::S_XF_R;
      mfga_pkg::S_XF_R:    state_nxt = (k_r == 2'd2) ? mfga_pkg::S_EMIT : mfga_pkg::S_XF_C;
      mfga_pkg::S_NR_ABS:  state_nxt = mfga_pkg::S_NR_MAX;
      mfga_pkg::S_NR_MAX: begin
        if (a_r[0] == '0 && a_r[1] == '0 && a_r[2] == '0) state_nxt = mfga_pkg::S_EMIT;
        else                                              state_nxt = mfga_pkg::S_NR_SH;
      end
      mfga_pkg::S_NR_SH:   if (m_r[31:30] != 2'b00) state_nxt = mfga_pkg::S_NR_MUL;
      mfga_pkg::S_NR_MUL:  state_nxt = mfga_pkg::S_NR_ACC;
      mfga_pkg::S_NR_ACC:  state_nxt = (k_r == 2'd2) ? mfga_pkg::S_NR_SQRT : mfga_pkg::S_NR_MUL;
      mfga_pkg::S_NR_SQRT: state_nxt = mfga_pkg::S_NR_SQW;
      mfga_pkg::S_NR_SQW:  if (sq_sts.done) state_nxt = mfga_pkg::S_NR_DIV;
      mfga_pkg::S_NR_DIV:  state_nxt = mfga_pkg::S_NR_DIVW;
      mfga_pkg::S_NR_DIVW: begin
        if (div_sts.done)
          state_nxt = (k_r == 2'd2) ? mfga_pkg::S_EMIT : mfga_pkg::S_NR_DIV;
      end
      mfga_pkg::S_EMIT: begin
        if (emit_go)
          state_nxt = (act_code_r == mfga_pkg::ACT_REPORT && !phase_r) ? mfga_pkg::S_DISP
                                                                       : mfga_pkg::S_IDLE;
      end
      default: state_nxt = mfga_pkg::S_IDLE;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfga_pkg::S_IDLE;
      fit_r       <= mfga_pkg::DEF_FIT[30:0];
      en_r        <= 1'b1;
      have_r      <= 1'b0;
      scale_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_addr == mfga_pkg::REG_FIT) begin
          fit_r      <= cfg_wdata;
          scale_ok_r <= 1'b0;
        end else begin
          en_r <= cfg_wdata[0];
        end
      end
      if (in_go && in_tuser == mfga_pkg::ACT_CLEAR) begin
        for (int i = 0; i < 3; i++) begin
          low_r[i]  <= '0;
          high_r[i] <= '0;
        end
        have_r     <= 1'b0;
        scale_ok_r <= 1'b0;
      end else if (in_go && in_tuser == mfga_pkg::ACT_ACCUM) begin
        for (int i = 0; i < 3; i++) begin
          if (!have_r || $signed(in_tdata[32*i +: 32]) < low_r[i])
            low_r[i] <= $signed(in_tdata[32*i +: 32]);
          if (!have_r || $signed(in_tdata[32*i +: 32]) > high_r[i])
            high_r[i] <= $signed(in_tdata[32*i +: 32]);
        end
        have_r     <= 1'b1;
        scale_ok_r <= 1'b0;
      end
      if (state_r == mfga_pkg::S_SCALE_W && div_sts.done) scale_ok_r <= 1'b1;
      if (emit_go)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      mfga_pkg::S_IDLE: begin
        act_code_r <= in_tuser;
        for (int i = 0; i < 3; i++) p_r[i] <= $signed(in_tdata[32*i +: 32]);
        k_r     <= 2'd0;
        ext_r   <= '0;
        phase_r <= 1'b0;
      end
      mfga_pkg::S_EXT: begin
        ext_r <= ext_step;
        k_r   <= k_r + 2'd1;
        if (k_r == 2'd2) act_r <= act_nxt;
      end
      mfga_pkg::S_SCALE_W: begin
        if (div_sts.done) scale_r <= (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
      mfga_pkg::S_DISP: begin
        k_r       <= 2'd0;
        applied_r <= 1'b0;
        src_r     <= (act_code_r != mfga_pkg::ACT_REPORT) ? mfga_pkg::SRC_PT
                   : (phase_r ? mfga_pkg::SRC_HI : mfga_pkg::SRC_LO);
        for (int i = 0; i < 3; i++) begin
          if (act_code_r != mfga_pkg::ACT_REPORT) res_r[i] <= p_r[i];
          else if (!have_r)                       res_r[i] <= '0;
          else                                    res_r[i] <= phase_r ? high_r[i] : low_r[i];
        end
      end
      mfga_pkg::S_XF_C: begin
        ctr_r <= (k_r == 2'd1) ? {low_r[1][31], low_r[1]} : ctr_sum;
      end
      mfga_pkg::S_XF_D: begin
        neg_r <= d_val[33];
        mag_r <= d_val[33] ? 33'(-d_val) : d_val[32:0];
      end
      mfga_pkg::S_XF_M: prod_r <= mul_p[63:0];
      mfga_pkg::S_XF_R: begin
        res_r[k_r] <= xf_out;
        k_r        <= k_r + 2'd1;
        if (k_r == 2'd2) applied_r <= 1'b1;
      end
      mfga_pkg::S_NR_ABS: begin
        for (int i = 0; i < 3; i++) begin
          sgn_r[i] <= p_r[i][31];
          a_r[i]   <= p_r[i][31] ? 32'(-p_r[i]) : p_r[i];
        end
      end
      mfga_pkg::S_NR_MAX: begin
        m_r <= (a_r[0] > a_r[1]) ? ((a_r[0] > a_r[2]) ? a_r[0] : a_r[2])
                                 : ((a_r[1] > a_r[2]) ? a_r[1] : a_r[2]);
        applied_r <= 1'b1;
        res_r[0]  <= '0;
        res_r[1]  <= $signed(mfga_pkg::ONE_FX);
        res_r[2]  <= '0;
      end
      mfga_pkg::S_NR_SH: begin
        k_r   <= 2'd0;
        sum_r <= '0;
        if (m_r[31:30] == 2'b00) begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
        end
      end
      mfga_pkg::S_NR_MUL: prod_r <= mul_p[63:0];
      mfga_pkg::S_NR_ACC: begin
        sum_r <= sum_r + prod_r;
        k_r   <= k_r + 2'd1;
      end
      mfga_pkg::S_NR_SQW: begin
        k_r <= 2'd0;
        if (sq_sts.done) len_r <= sq_root;
      end
      mfga_pkg::S_NR_DIVW: begin
        if (div_sts.done) begin
          res_r[k_r] <= sgn_r[k_r] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
          k_r        <= k_r + 2'd1;
        end
      end
      mfga_pkg::S_EMIT: begin
        if (emit_go) phase_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (emit_go) begin
      ox_r    <= res_r[0];
      oy_r    <= res_r[1];
      oz_r    <= res_r[2];
      oapp_r  <= applied_r;
      olast_r <= (act_code_r != mfga_pkg::ACT_REPORT) || phase_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {oz_r, oy_r, ox_r};
  assign out_tuser[0] = oapp_r;
  assign out_tlast    = olast_r;

  // ---- assertions ----
  `MFGA_ASSERT_IMPL(a_box_ordered, have_r,
    low_r[0] <= high_r[0] && low_r[1] <= high_r[1] && low_r[2] <= high_r[2])
  `MFGA_ASSERT_NEXT(a_clear_empties, in_go && in_tuser == mfga_pkg::ACT_CLEAR,
    !have_r && !scale_ok_r)
  `MFGA_ASSERT_IMPL(a_applied_has_scale, emit_go && applied_r && act_code_r != mfga_pkg::ACT_RENORM,
    scale_ok_r && have_r)
  `MFGA_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_sts.busy && !sq_sts.busy)

endmodule

@@ sv/mfga_div.sv @@
// ---------------------------------------------------------------------------
// mfga_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mfga_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mfga_pkg::div_req_t               req,
  output mfga_pkg::unit_sts_t              sts,
  output logic [mfga_pkg::DIV_NUM_W-1:0]   quo
);

  localparam int CW = $clog2(mfga_pkg::DIV_NUM_W + 1);

  logic [CW-1:0]                    cnt_r;
  logic                             done_r;
  logic [mfga_pkg::DIV_DEN_W-1:0]   rem_r;
  logic [mfga_pkg::DIV_NUM_W-1:0]   q_r;
  logic [mfga_pkg::DIV_DEN_W-1:0]   den_r;
  logic [mfga_pkg::DIV_DEN_W:0]     trial;
  logic                             fits;

  assign trial = {rem_r, q_r[mfga_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= CW'(mfga_pkg::DIV_NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      q_r   <= req.num;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? mfga_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                    : trial[mfga_pkg::DIV_DEN_W-1:0];
      q_r   <= {q_r[mfga_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign sts.busy = cnt_r != '0;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

@@ sv/mfga_sqrt.sv @@
// ---------------------------------------------------------------------------
// mfga_sqrt
// Integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module mfga_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mfga_pkg::SQRT_IN_W-1:0]    radicand,
  output mfga_pkg::unit_sts_t               sts,
  output logic [mfga_pkg::SQRT_OUT_W-1:0]   root
);

  localparam int OW = mfga_pkg::SQRT_OUT_W;
  localparam int CW = $clog2(OW + 1);

  logic [CW-1:0]                    cnt_r;
  logic                             done_r;
  logic [OW+1:0]                    rem_r;
  logic [OW-1:0]                    root_r;
  logic [mfga_pkg::SQRT_IN_W-1:0]   v_r;
  logic [OW+3:0]                    tmp;
  logic [OW+3:0]                    trial;

  assign tmp   = {rem_r, v_r[mfga_pkg::SQRT_IN_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(OW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      root_r <= '0;
      v_r    <= radicand;
    end else if (cnt_r != '0) begin
      v_r <= v_r << 2;
      if (tmp >= trial) begin
        rem_r  <= (OW+2)'(tmp - trial);
        root_r <= {root_r[OW-2:0], 1'b1};
      end else begin
        rem_r  <= tmp[OW+1:0];
        root_r <= {root_r[OW-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = cnt_r != '0;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule
